### rtl/clim_pkg.sv
// Shared types and constants for the colormap linear interpolator.
// Holds the palette ROM, register map codes and the RGB struct.
// No dependencies; used by every module of the block.
package clim_pkg;

    // Palette ROM depth and index width
    localparam int ROM_LEN = 11;
    localparam int IDX_W   = 4;

    // Register map: index taken from paddr[3:2]
    localparam int        ADDR_W         = 4;
    localparam logic [1:0] REG_RANGE_LOW  = 2'd0;
    localparam logic [1:0] REG_RANGE_HIGH = 2'd1;
    localparam logic [1:0] REG_BIN_SCALE  = 2'd2;

    // Register reset values
    localparam logic [31:0] RST_RANGE_LOW  = 32'd0;
    localparam logic [31:0] RST_RANGE_HIGH = 32'd655360;
    localparam logic [31:0] RST_BIN_SCALE  = 32'd65536;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_rgb;

    // Diverging palette, dark blue through white to dark red.
    // Entries past the table read as black; the blend never weights them.
    function automatic t_rgb palette_color(input logic [IDX_W-1:0] idx);
        t_rgb c;
        unique case (idx)
            4'd0:    c = '{red: 8'h05, green: 8'h30, blue: 8'h61};
            4'd1:    c = '{red: 8'h21, green: 8'h66, blue: 8'hac};
            4'd2:    c = '{red: 8'h43, green: 8'h93, blue: 8'hc3};
            4'd3:    c = '{red: 8'h92, green: 8'hc5, blue: 8'hde};
            4'd4:    c = '{red: 8'hd1, green: 8'he5, blue: 8'hf0};
            4'd5:    c = '{red: 8'hf7, green: 8'hf7, blue: 8'hf7};
            4'd6:    c = '{red: 8'hfd, green: 8'hdb, blue: 8'hc7};
            4'd7:    c = '{red: 8'hf4, green: 8'ha5, blue: 8'h82};
            4'd8:    c = '{red: 8'hd6, green: 8'h60, blue: 8'h4d};
            4'd9:    c = '{red: 8'hb2, green: 8'h18, blue: 8'h2b};
            4'd10:   c = '{red: 8'h67, green: 8'h00, blue: 8'h1f};
            default: c = '{red: 8'h00, green: 8'h00, blue: 8'h00};
        endcase
        return c;
    endfunction

endpackage

### rtl/clim_index.sv
// Front half of the colormap pipeline: range test, offset, scale multiply
// and palette bin / residual decode (three register stages).
// Depends on clim_pkg.
module clim_index #(
    parameter int NUM_COLORS = 11,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [31:0]                   i_sample,
    input  logic [31:0]                   i_range_low,
    input  logic [31:0]                   i_range_high,
    input  logic [31:0]                   i_bin_scale,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [clim_pkg::IDX_W-1:0]    o_idx,
    output logic [FRAC_BITS-1:0]          o_res
);

    localparam int PAL_LEN  = (NUM_COLORS > clim_pkg::ROM_LEN) ? clim_pkg::ROM_LEN : NUM_COLORS;
    localparam int LAST_INT = PAL_LEN - 1;
    localparam logic [31:0] LAST_VEC = LAST_INT;
    localparam logic [clim_pkg::IDX_W-1:0] LAST_IDX = LAST_VEC[clim_pkg::IDX_W-1:0];
    localparam int BIN_LSB  = 2 * FRAC_BITS;
    localparam int HIGH_LSB = BIN_LSB + clim_pkg::IDX_W;

    // Stage enables: a stage moves when empty or when the next one moves
    logic w_en1, w_en2, w_en3;
    logic r_s1_v, r_s2_v, r_s3_v;

    assign w_en3   = !r_s3_v || i_ready;
    assign w_en2   = !r_s2_v || w_en3;
    assign w_en1   = !r_s1_v || w_en2;
    assign o_ready = w_en1;

    // Stage 1: bound compares and offset from the low bound
    logic        r_s1_hi, r_s1_lo;
    logic [31:0] r_s1_off;
    logic [32:0] w_diff;

    assign w_diff = {i_sample[31], i_sample} - {i_range_low[31], i_range_low};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_en1) begin
            r_s1_v <= i_valid;
        end
        if (w_en1) begin
            r_s1_hi  <= $signed(i_sample) >= $signed(i_range_high);
            r_s1_lo  <= $signed(i_sample) <  $signed(i_range_low);
            r_s1_off <= w_diff[31:0];
        end
    end

    // Stage 2: exact 32x32 product of offset and bin scale
    logic        r_s2_hi, r_s2_lo;
    logic [63:0] r_s2_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (w_en2) begin
            r_s2_v <= r_s1_v;
        end
        if (w_en2) begin
            r_s2_hi   <= r_s1_hi;
            r_s2_lo   <= r_s1_lo;
            r_s2_prod <= 64'(r_s1_off) * 64'(i_bin_scale);
        end
    end

    // Stage 3: bin index and residual, saturated to the palette ends
    logic                       w_over;
    logic [clim_pkg::IDX_W-1:0] n_idx;
    logic [FRAC_BITS-1:0]       n_res;
    logic [clim_pkg::IDX_W-1:0] r_s3_idx;
    logic [FRAC_BITS-1:0]       r_s3_res;

    assign w_over = (|r_s2_prod[63:HIGH_LSB])
                 || (r_s2_prod[HIGH_LSB-1:BIN_LSB] >= LAST_IDX);

    always_comb begin
        priority if (r_s2_hi) begin
            n_idx = LAST_IDX;
            n_res = '0;
        end else if (r_s2_lo) begin
            n_idx = '0;
            n_res = '0;
        end else if (w_over) begin
            n_idx = LAST_IDX;
            n_res = '0;
        end else begin
            n_idx = r_s2_prod[HIGH_LSB-1:BIN_LSB];
            n_res = r_s2_prod[BIN_LSB-1:FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (w_en3) begin
            r_s3_v <= r_s2_v;
        end
        if (w_en3) begin
            r_s3_idx <= n_idx;
            r_s3_res <= n_res;
        end
    end

    assign o_valid = r_s3_v;
    assign o_idx   = r_s3_idx;
    assign o_res   = r_s3_res;

endmodule

### rtl/clim_blend.sv
// Back half of the colormap pipeline: palette ROM read and per-channel
// linear blend into the output register (two register stages).
// Depends on clim_pkg.
module clim_blend #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [clim_pkg::IDX_W-1:0] i_idx,
    input  logic [FRAC_BITS-1:0]       i_res,
    output logic                       o_valid,
    input  logic                       i_ready,
    output clim_pkg::t_rgb             o_rgb
);

    localparam int MIX_W = FRAC_BITS + 10;

    logic w_en4, w_en5;
    logic r_s4_v, r_s5_v;

    assign w_en5   = !r_s5_v || i_ready;
    assign w_en4   = !r_s4_v || w_en5;
    assign o_ready = w_en4;

    // Stage 4: read both neighbors, keep base color and signed step
    clim_pkg::t_rgb             w_c0, w_c1;
    logic [clim_pkg::IDX_W-1:0] w_idx_nx;
    logic [7:0]                 w_c0_ch [3];
    logic [7:0]                 w_c1_ch [3];
    logic [7:0]                 r_s4_c0 [3];
    logic signed [8:0]          r_s4_d [3];
    logic [FRAC_BITS-1:0]       r_s4_res;

    assign w_idx_nx = i_idx + 1'b1;
    assign w_c0     = clim_pkg::palette_color(i_idx);
    assign w_c1     = clim_pkg::palette_color(w_idx_nx);
    assign w_c0_ch[0] = w_c0.red;
    assign w_c0_ch[1] = w_c0.green;
    assign w_c0_ch[2] = w_c0.blue;
    assign w_c1_ch[0] = w_c1.red;
    assign w_c1_ch[1] = w_c1.green;
    assign w_c1_ch[2] = w_c1.blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
        end else if (w_en4) begin
            r_s4_v <= i_valid;
        end
        if (w_en4) begin
            for (int k = 0; k < 3; k++) begin
                r_s4_c0[k] <= w_c0_ch[k];
                r_s4_d[k]  <= $signed({1'b0, w_c1_ch[k]}) - $signed({1'b0, w_c0_ch[k]});
            end
            r_s4_res <= i_res;
        end
    end

    // Stage 5: c0*2^F + (c1-c0)*res, keep the integer byte
    logic signed [MIX_W-1:0] w_mix [3];
    logic [7:0]              w_ch  [3];
    clim_pkg::t_rgb          r_s5_rgb;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_mix[k] = $signed({2'b00, r_s4_c0[k], {FRAC_BITS{1'b0}}})
                     + MIX_W'(r_s4_d[k]) * $signed(MIX_W'({1'b0, r_s4_res}));
            w_ch[k]  = w_mix[k][FRAC_BITS+7:FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_v <= 1'b0;
        end else if (w_en5) begin
            r_s5_v <= r_s4_v;
        end
        if (w_en5) begin
            r_s5_rgb <= '{red: w_ch[0], green: w_ch[1], blue: w_ch[2]};
        end
    end

    assign o_valid = r_s5_v;
    assign o_rgb   = r_s5_rgb;

endmodule

### rtl/colormap_linear_interpolator.sv
// Top level of the colormap linear interpolator: register file and the
// two pipeline halves. Depends on clim_pkg, clim_index and clim_blend.
//
// Usage:
//   Slave stream takes one signed Q16.16 sample per request in tdata.
//   Master stream returns one RGB request per sample: red in bits 7:0,
//   green in 15:8, blue in 23:16. Results come out in input order.
//   APB port holds range_low (0x0), range_high (0x4) and bin_scale (0x8);
//   write them only while the pipeline is empty.
// Pipeline: five register stages (compare/offset, 32x32 multiply, bin
//   decode, ROM read, blend into output register).
// Throughput: one sample per cycle while the receiver keeps tready high;
//   the 32x32 multiply stage sets the clock budget.
// Reset: all stage valid bits clear, registers return to 0 / 10.0 / 1.0.
// Stall: when the receiver holds tready low, each stage holds its request;
//   empty stages still fill, and the input stalls only once all five
//   stages are full. Nothing is dropped or repeated.
module colormap_linear_interpolator #(
    parameter int NUM_COLORS = 11,
    parameter int FRAC_BITS  = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input stream; tdata: sample_value[31:0]
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [31:0]                 i_s_axis_tdata,
    // output stream; tdata: red[7:0], green[15:8], blue[23:16]
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [23:0]                 o_m_axis_tdata,
    // configuration port
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [clim_pkg::ADDR_W-1:0] i_paddr,
    input  logic [31:0]                 i_pwdata,
    output logic [31:0]                 o_prdata,
    output logic                        o_pready
);

    // Configuration registers
    logic [31:0] r_range_low, r_range_high, r_bin_scale;
    logic        w_wr;
    logic [1:0]  w_reg;

    assign o_pready = 1'b1;
    assign w_wr     = i_psel && i_penable && i_pwrite && o_pready;
    assign w_reg    = i_paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_low  <= clim_pkg::RST_RANGE_LOW;
            r_range_high <= clim_pkg::RST_RANGE_HIGH;
            r_bin_scale  <= clim_pkg::RST_BIN_SCALE;
        end else if (w_wr) begin
            unique case (w_reg)
                clim_pkg::REG_RANGE_LOW:  r_range_low  <= i_pwdata;
                clim_pkg::REG_RANGE_HIGH: r_range_high <= i_pwdata;
                clim_pkg::REG_BIN_SCALE:  r_bin_scale  <= i_pwdata;
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (w_reg)
            clim_pkg::REG_RANGE_LOW:  o_prdata = r_range_low;
            clim_pkg::REG_RANGE_HIGH: o_prdata = r_range_high;
            clim_pkg::REG_BIN_SCALE:  o_prdata = r_bin_scale;
            default:                  o_prdata = '0;
        endcase
    end

    // Pipeline halves
    logic                       w_mid_valid, w_mid_ready;
    logic [clim_pkg::IDX_W-1:0] w_mid_idx;
    logic [FRAC_BITS-1:0]       w_mid_res;
    clim_pkg::t_rgb             w_rgb;

    clim_index #(
        .NUM_COLORS (NUM_COLORS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_index (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_sample     (i_s_axis_tdata),
        .i_range_low  (r_range_low),
        .i_range_high (r_range_high),
        .i_bin_scale  (r_bin_scale),
        .o_valid      (w_mid_valid),
        .i_ready      (w_mid_ready),
        .o_idx        (w_mid_idx),
        .o_res        (w_mid_res)
    );

    clim_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mid_valid),
        .o_ready (w_mid_ready),
        .i_idx   (w_mid_idx),
        .i_res   (w_mid_res),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_rgb   (w_rgb)
    );

    assign o_m_axis_tdata = w_rgb;

endmodule

### rtl/clim_checker.sv
// Port-level checks for the colormap linear interpolator, bound to the top.
// Depends on colormap_linear_interpolator and clim_pkg.
module clim_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_s_axis_tready,
    input logic                        o_m_axis_tvalid,
    input logic                        i_m_axis_tready,
    input logic [23:0]                 o_m_axis_tdata,
    input logic                        i_psel,
    input logic                        i_penable,
    input logic                        i_pwrite,
    input logic [clim_pkg::ADDR_W-1:0] i_paddr,
    input logic [31:0]                 i_pwdata,
    input logic [31:0]                 o_prdata,
    input logic                        o_pready
);

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // Stalled output request holds its data
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled output request changed");

    // Input backpressure only when the output is stalled
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid && !i_m_axis_tready)
        else $error("input stalled while output free");

    // Configuration port never waits
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pready)
        else $error("pready low");

    // A write to a register reads back on the next cycle at the same address
    a_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_psel && i_penable && i_pwrite && (i_paddr[3:2] != 2'd3)
        |=> !(i_paddr == $past(i_paddr)) || (o_prdata == $past(i_pwdata)))
        else $error("register readback mismatch");

endmodule

bind colormap_linear_interpolator clim_checker u_clim_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .i_psel          (i_psel),
    .i_penable       (i_penable),
    .i_pwrite        (i_pwrite),
    .i_paddr         (i_paddr),
    .i_pwdata        (i_pwdata),
    .o_prdata        (o_prdata),
    .o_pready        (o_pready)
);
